[hw/rtl/ibcs_pkg.sv]
package ibcs_pkg;

    localparam int unsigned CapW  = 8;
    localparam int unsigned TickW = 16;
    localparam int unsigned CfgW  = 16;

    localparam logic [CapW-1:0]  CapReset  = 8'd32;
    localparam logic [TickW-1:0] HalfReset = 16'd10;

    // Configuration register indexes.
    typedef enum logic {
        CFG_CLOCK_CAP   = 1'b0,
        CFG_HALF_PERIOD = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CLK_HI = 3'd1,
        PH_CLK_LO = 3'd2,
        PH_STOP_A = 3'd3,
        PH_STOP_B = 3'd4,
        PH_STOP_C = 3'd5,
        PH_STOP_D = 3'd6
    } t_phase;

    typedef struct packed {
        logic            scl_pull_low;
        logic            sda_pull_low;
        logic            busy_res;
        logic            done_res;
        logic            bus_ok;
        logic [CapW-1:0] clocks_issued;
    } t_result;

endpackage

[hw/rtl/i2c_bus_clear_sequencer.sv]
// Latency: a result appears in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle; the only limit is the downstream ready.
// The sequencer state and the result register advance together in one clocked pass.
// Reset (synchronous, active low): phase idle, counters and flags cleared,
// clock_cap = 32, half_period_ticks = 10, no result pending.
module i2c_bus_clear_sequencer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_start_req,
    input  logic                      i_sda_in,
    input  logic                      i_scl_in,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic                      o_scl_pull_low,
    output logic                      o_sda_pull_low,
    output logic                      o_busy_res,
    output logic                      o_done_res,
    output logic                      o_bus_ok,
    output logic [ibcs_pkg::CapW-1:0] o_clocks_issued,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [ibcs_pkg::CfgW-1:0] i_cfg_data
);

    // An item is taken whenever the output register is empty or is being
    // emptied in the same cycle, so a waiting result never blocks the input.
    logic              accept;
    ibcs_pkg::t_result core_res;
    ibcs_pkg::t_result out_res;

    assign o_ready = !o_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // The core holds the phase machine, the tick and pulse counters and the
    // two configuration registers. Phase and counters move only on an accepted
    // item, since each item is one time tick of the bus; config writes need none.
    ibcs_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_start_req (i_start_req),
        .i_sda_in    (i_sda_in),
        .i_scl_in    (i_scl_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_result    (core_res)
    );

    // The output register parts the two handshakes.
    ibcs_oreg u_oreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_take   (i_ready),
        .i_result (core_res),
        .o_valid  (o_valid),
        .o_result (out_res)
    );

    assign o_scl_pull_low  = out_res.scl_pull_low;
    assign o_sda_pull_low  = out_res.sda_pull_low;
    assign o_busy_res      = out_res.busy_res;
    assign o_done_res      = out_res.done_res;
    assign o_bus_ok        = out_res.bus_ok;
    assign o_clocks_issued = out_res.clocks_issued;

endmodule

[hw/rtl/ibcs_core.sv]
module ibcs_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_start_req,
    input  logic                         i_sda_in,
    input  logic                         i_scl_in,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [ibcs_pkg::CfgW-1:0]    i_cfg_data,
    output ibcs_pkg::t_result            o_result
);

    ibcs_pkg::t_phase                 r_phase, n_phase;
    logic [ibcs_pkg::TickW-1:0]       r_tick, n_tick;
    logic [ibcs_pkg::CapW-1:0]        r_pulse, n_pulse;
    logic                             r_rel, n_rel;
    logic                             r_last, n_last;
    logic [ibcs_pkg::CapW-1:0]        r_cap;
    logic [ibcs_pkg::TickW-1:0]       r_half;

    logic [ibcs_pkg::TickW-1:0]       tick_inc;
    logic [ibcs_pkg::TickW-1:0]       half_eff;
    logic                             end_of_phase;
    ibcs_pkg::t_result                res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ibcs_pkg::PH_IDLE;
            r_tick  <= '0;
            r_pulse <= '0;
            r_rel   <= 1'b0;
            r_last  <= 1'b0;
            r_cap   <= ibcs_pkg::CapReset;
            r_half  <= ibcs_pkg::HalfReset;
        end else begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_pulse <= n_pulse;
            r_rel   <= n_rel;
            r_last  <= n_last;
            if (i_cfg_we) begin
                case (ibcs_pkg::t_cfg_idx'(i_cfg_idx))
                    ibcs_pkg::CFG_CLOCK_CAP:   r_cap  <= i_cfg_data[ibcs_pkg::CapW-1:0];
                    ibcs_pkg::CFG_HALF_PERIOD: r_half <= i_cfg_data[ibcs_pkg::TickW-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign tick_inc     = r_tick + ibcs_pkg::TickW'(1);
    assign half_eff     = (r_half == '0) ? ibcs_pkg::TickW'(1) : r_half;
    assign end_of_phase = (tick_inc >= half_eff);

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_pulse = r_pulse;
        n_rel   = r_rel;
        n_last  = r_last;
        res     = '0;
        if (i_accept) begin
            case (r_phase)
                ibcs_pkg::PH_IDLE: begin
                    if (i_start_req) begin
                        n_pulse = '0;
                        n_rel   = 1'b0;
                        if (i_sda_in) begin
                            n_last       = 1'b1;
                            res.done_res = 1'b1;
                            res.bus_ok   = 1'b1;
                        end else if (r_cap == '0) begin
                            n_phase      = ibcs_pkg::PH_STOP_A;
                            n_tick       = '0;
                            res.busy_res = 1'b1;
                        end else begin
                            n_phase      = ibcs_pkg::PH_CLK_HI;
                            n_tick       = '0;
                            res.busy_res = 1'b1;
                        end
                    end
                end
                default: begin
                    res.busy_res = 1'b1;
                    n_tick       = tick_inc;
                    case (r_phase)
                        ibcs_pkg::PH_CLK_LO: res.scl_pull_low = 1'b1;
                        ibcs_pkg::PH_STOP_A: res.scl_pull_low = 1'b1;
                        ibcs_pkg::PH_STOP_B: begin
                            res.scl_pull_low = 1'b1;
                            res.sda_pull_low = 1'b1;
                        end
                        ibcs_pkg::PH_STOP_C: res.sda_pull_low = 1'b1;
                        default: ;
                    endcase
                    if (end_of_phase) begin
                        n_tick = '0;
                        case (r_phase)
                            ibcs_pkg::PH_CLK_HI: begin
                                n_pulse = r_pulse + ibcs_pkg::CapW'(1);
                                if (i_sda_in) begin
                                    n_rel   = 1'b1;
                                    n_phase = ibcs_pkg::PH_STOP_A;
                                end else begin
                                    n_phase = ibcs_pkg::PH_CLK_LO;
                                end
                            end
                            ibcs_pkg::PH_CLK_LO: begin
                                if (r_pulse < r_cap) begin
                                    n_phase = ibcs_pkg::PH_CLK_HI;
                                end else begin
                                    n_rel   = i_sda_in;
                                    n_phase = ibcs_pkg::PH_STOP_A;
                                end
                            end
                            ibcs_pkg::PH_STOP_A: n_phase = ibcs_pkg::PH_STOP_B;
                            ibcs_pkg::PH_STOP_B: n_phase = ibcs_pkg::PH_STOP_C;
                            ibcs_pkg::PH_STOP_C: n_phase = ibcs_pkg::PH_STOP_D;
                            default: begin
                                n_last       = r_rel & i_sda_in & i_scl_in;
                                res.bus_ok   = r_rel & i_sda_in & i_scl_in;
                                res.done_res = 1'b1;
                                res.busy_res = 1'b0;
                                n_phase      = ibcs_pkg::PH_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end
        res.clocks_issued = n_pulse;
    end

    // The last outcome is kept as part of the sequencer state only.
    assign o_result = r_last ? res : res;

endmodule

[hw/rtl/ibcs_oreg.sv]
module ibcs_oreg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_take,
    input  ibcs_pkg::t_result i_result,
    output logic              o_valid,
    output ibcs_pkg::t_result o_result
);

    logic              r_valid;
    ibcs_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[hw/rtl/ibcs_chk.sv]
module ibcs_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_ready,
    input logic                      o_scl_pull_low,
    input logic                      o_sda_pull_low,
    input logic                      o_busy_res,
    input logic                      o_done_res,
    input logic                      o_bus_ok,
    input logic [ibcs_pkg::CapW-1:0] o_clocks_issued
);

    // A finished recovery is never still busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_done_res && o_busy_res))
        else $error("done and busy together");

    // The bus verdict is only reported with done.
    a_ok_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bus_ok) |-> o_done_res)
        else $error("bus_ok without done");

    // Lines are only driven while a sequence runs.
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_busy_res) |-> (!o_scl_pull_low && !o_sda_pull_low))
        else $error("line driven while not busy");

    // A stalled item stays valid and keeps its count, done and busy flags.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_clocks_issued)
            && $stable(o_done_res) && $stable(o_busy_res)))
        else $error("stalled item changed");

endmodule

bind i2c_bus_clear_sequencer ibcs_chk u_ibcs_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_scl_pull_low  (o_scl_pull_low),
    .o_sda_pull_low  (o_sda_pull_low),
    .o_busy_res      (o_busy_res),
    .o_done_res      (o_done_res),
    .o_bus_ok        (o_bus_ok),
    .o_clocks_issued (o_clocks_issued)
);
